// ===== hw/rtl/calendar_date_arithmetic_core_defines.svh =====
// Assertion macros shared by the calendar date arithmetic RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cda_pkg.sv =====
// Package for the calendar date arithmetic core: field widths, opcodes,
// calendar block sizes and month length lookup. No dependencies.
package cda_pkg;

	localparam int OPCODE_W = 3;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DELTA_W  = 20;
	localparam int ORD_W    = 22;

	localparam int YEAR_MAX_DEF   = 9999;
	localparam int DELTA_BITS_DEF = 20;

	localparam logic [OPCODE_W-1:0] OP_NEXT  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PREV  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ADD   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SUB   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DOY   = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_EPOCH = 3'd5;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Block stages of the year walk: 400, 100, 4 and 1 year(s).
	typedef logic [1:0] stage_t;
	localparam stage_t STG_400 = 2'd0;
	localparam stage_t STG_100 = 2'd1;
	localparam stage_t STG_4   = 2'd2;
	localparam stage_t STG_1   = 2'd3;

	localparam int YBLK_W = 9;
	localparam int DBLK_W = 18;

	function automatic logic [YBLK_W-1:0] year_blk(stage_t s);
		logic [YBLK_W-1:0] r;
		case (s)
			STG_400: r = 9'd400;
			STG_100: r = 9'd100;
			STG_4:   r = 9'd4;
			default: r = 9'd1;
		endcase
		return r;
	endfunction

	function automatic logic [DBLK_W-1:0] day_blk(stage_t s);
		logic [DBLK_W-1:0] r;
		case (s)
			STG_400: r = 18'd146097;
			STG_100: r = 18'd36524;
			STG_4:   r = 18'd1461;
			default: r = 18'd365;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			MONTH_FEB: r = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// Day number of 31 December of the given year (30 December if it is a leap year), 1 January of year 1 being 0.
	function automatic int unsigned epoch_last(int unsigned ymax);
		int unsigned p;
		p = ymax - 1;
		return p * 365 + p / 4 - p / 100 + p / 400 + 364;
	endfunction

endpackage

// ===== hw/rtl/cda_if.sv =====
// Valid/ready channels of the calendar date arithmetic core.
// Depends on cda_pkg for the field widths.
interface cda_req_if import cda_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [YEAR_W-1:0]   year_in;
	logic [MONTH_W-1:0]  month_in;
	logic [DAY_W-1:0]    day_in;
	logic [DELTA_W-1:0]  day_delta;

	modport source (output valid, opcode, year_in, month_in, day_in, day_delta,
		input ready);
	modport sink (input valid, opcode, year_in, month_in, day_in, day_delta,
		output ready);
endinterface

interface cda_rsp_if import cda_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year_out;
	logic [MONTH_W-1:0] month_out;
	logic [DAY_W-1:0]   day_out;
	logic [ORD_W-1:0]   ordinal;
	logic               error;

	modport source (output valid, year_out, month_out, day_out, ordinal, error,
		input ready);
	modport sink (input valid, year_out, month_out, day_out, ordinal, error,
		output ready);
endinterface

// ===== hw/rtl/calendar_date_arithmetic_core.sv =====
// Gregorian date calculator: next/previous day, add/subtract days, day of year, epoch count.
// Depends on cda_pkg, the channels in cda_if.sv and the assertion macros header.
//
// Usage
//   req (sink):  one word = opcode, date, day_delta. Taken only while the core is idle.
//   rsp (source): one word per request = result date, ordinal, error flag.
// Operation
//   The date is turned into a day number by a walk over 400/100/4/1-year blocks and then
//   over the months, all through one shared day adder and one year adder. Date opcodes
//   add or subtract the step and walk the blocks back down to a date.
// Throughput
//   One request at a time. With the default YEAR_MAX, a year walk steps over at most 24
//   400-year, 3 100-year, 24 4-year and 3 1-year blocks, then over the months; date opcodes
//   walk both ways. A bad year, month or zero day skips both walks and goes straight to
//   the result. req.ready returns in the cycle after the result is loaded.
// Stalls and reset
//   Results sit in an output register, so the next request is taken while an earlier
//   result still waits; a finished result is held in the core until that register frees.
//   arst_n clears the sequencer and the output valid; no result is pending after reset.
`include "calendar_date_arithmetic_core_defines.svh"

module calendar_date_arithmetic_core import cda_pkg::*; #(
	parameter int YEAR_MAX   = YEAR_MAX_DEF,
	parameter int DELTA_BITS = DELTA_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cda_req_if.sink    req,
	cda_rsp_if.source  rsp
);

	// Widths that follow from the parameters.
	localparam int          YMAX_W     = $clog2(YEAR_MAX + 1);
	localparam int          YW         = (YMAX_W > YEAR_W) ? YMAX_W : YEAR_W;
	localparam int unsigned EPOCH_LAST = epoch_last(YEAR_MAX);
	localparam int          EW         = $clog2(EPOCH_LAST + 1);
	localparam int          DBW        = (DELTA_BITS < DELTA_W) ? DELTA_BITS : DELTA_W;
	localparam int          DW         = ((EW > DBW) ? EW : DBW) + 1;

	localparam logic [YW-1:0] YMAX_V = YW'(YEAR_MAX);
	localparam logic [DW-1:0] LAST_V = DW'(EPOCH_LAST);

	// Block counts that mark a leap year at the end of a walk.
	localparam logic [4:0] N4_CENTURY = 5'd24;
	localparam logic [1:0] N100_LAST  = 2'd3;
	localparam logic [4:0] N1_LAST    = 5'd3;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FWD   = 4'd1;
	localparam logic [3:0] S_MON   = 4'd2;
	localparam logic [3:0] S_DOY   = 4'd3;
	localparam logic [3:0] S_EPOCH = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_REV   = 4'd6;
	localparam logic [3:0] S_RMON  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]          state_q;
	stage_t              stage_q;
	logic [4:0]          cnt_q;
	logic [1:0]          n100_q;
	logic [4:0]          n4_q;
	logic                leap_q;
	logic [MONTH_W-1:0]  mo_q;

	// Latched request.
	logic [OPCODE_W-1:0] op_q;
	logic [MONTH_W-1:0]  m_q;
	logic [DAY_W-1:0]    d_q;
	logic [DBW-1:0]      delta_q;

	// Working registers: year side and day side of the shared unit.
	logic [YW-1:0]       yreg_q;
	logic [DW-1:0]       dreg_q;
	logic [DW-1:0]       ydays_q;

	// Result held until the output register is free.
	logic [YEAR_W-1:0]   res_y_q;
	logic [MONTH_W-1:0]  res_m_q;
	logic [DAY_W-1:0]    res_d_q;
	logic [ORD_W-1:0]    res_ord_q;
	logic                res_err_q;

	// Output register.
	logic                ovld_q;
	logic [YEAR_W-1:0]   oy_q;
	logic [MONTH_W-1:0]  om_q;
	logic [DAY_W-1:0]    od_q;
	logic [ORD_W-1:0]    oord_q;
	logic                oerr_q;

	logic                accept;
	logic                pre_ok;
	logic                load;
	logic                is_sub_op;
	logic                leap_next;
	logic                rev_cap;
	logic [DAY_W-1:0]    len_mo;
	logic [DAY_W-1:0]    len_m;

	// Shared units.
	logic                ysub;
	logic [YW-1:0]       yop;
	logic [YW:0]         ysum;
	logic                dsub;
	logic [DW-1:0]       dop;
	logic [DW-1:0]       dsum;
	logic [ORD_W+DW-1:0] ord_ext;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load      = (state_q == S_DONE) && (!ovld_q || rsp.ready);
	assign is_sub_op = (op_q == OP_PREV) || (op_q == OP_SUB);

	// Coarse date check; the day against the month length waits for the leap flag.
	assign pre_ok = (req.year_in != '0) && (YW'(req.year_in) <= YMAX_V) &&
		(req.month_in != '0) && (req.month_in <= MONTH_DEC) && (req.day_in != '0);

	// Leap year: last year of a 4-block, unless a century that is not the fourth.
	assign leap_next = (cnt_q == N1_LAST) && ((n4_q != N4_CENTURY) || (n100_q == N100_LAST));

	// The walk back down may take at most three 100-year and three 1-year blocks.
	assign rev_cap = ((stage_q == STG_100) || (stage_q == STG_1)) && (cnt_q == N1_LAST);

	assign len_mo  = month_len(mo_q, leap_q);
	assign len_m   = month_len(m_q, leap_q);
	assign ord_ext = {{ORD_W{1'b0}}, dreg_q};

	// Operand selection for the year and day adders.
	always_comb begin
		ysub = (state_q == S_FWD);
		yop  = YW'(year_blk(stage_q));
		dsub = 1'b0;
		dop  = '0;
		case (state_q)
			S_FWD: begin
				dop = DW'(day_blk(stage_q));
			end
			S_MON: begin
				if (mo_q < m_q) begin
					dop = DW'(len_mo);
				end else begin
					dop = DW'(d_q) - DW'(1);
				end
			end
			S_DOY: begin
				dop = ydays_q;
			end
			S_EPOCH: begin
				dsub = is_sub_op;
				if ((op_q == OP_NEXT) || (op_q == OP_PREV)) begin
					dop = DW'(1);
				end else begin
					dop = DW'(delta_q);
				end
			end
			S_REV: begin
				dsub = 1'b1;
				dop  = DW'(day_blk(stage_q));
			end
			S_RMON: begin
				dsub = 1'b1;
				dop  = DW'(len_mo);
			end
			default: begin
				dop = '0;
			end
		endcase
	end

	assign ysum = {1'b0, yreg_q} + ({1'b0, yop} ^ {(YW+1){ysub}}) + (YW+1)'(ysub);
	assign dsum = dreg_q + (dop ^ {DW{dsub}}) + DW'(dsub);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= STG_400;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= pre_ok ? S_FWD : S_DONE;
						stage_q <= STG_400;
						cnt_q   <= '0;
					end
				end
				S_FWD: begin
					if (!ysum[YW]) begin
						if (stage_q != STG_400) begin
							cnt_q <= cnt_q + 5'd1;
						end
					end else begin
						cnt_q <= '0;
						if (stage_q == STG_1) begin
							state_q <= S_MON;
						end else begin
							stage_q <= stage_q + 2'd1;
						end
					end
				end
				S_MON: begin
					if (mo_q >= m_q) begin
						state_q <= (d_q > len_m) ? S_DONE : S_DOY;
					end
				end
				S_DOY: begin
					if (op_q == OP_DOY || op_q > OP_EPOCH) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_EPOCH;
					end
				end
				S_EPOCH: begin
					state_q <= (op_q == OP_EPOCH) ? S_DONE : S_CHK;
				end
				S_CHK: begin
					stage_q <= STG_400;
					cnt_q   <= '0;
					if ((is_sub_op && dreg_q[DW-1]) || (!is_sub_op && dreg_q > LAST_V)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_REV;
					end
				end
				S_REV: begin
					if (!dsum[DW-1] && !rev_cap) begin
						if (stage_q != STG_400) begin
							cnt_q <= cnt_q + 5'd1;
						end
					end else begin
						cnt_q <= '0;
						if (stage_q == STG_1) begin
							state_q <= S_RMON;
						end else begin
							stage_q <= stage_q + 2'd1;
						end
					end
				end
				S_RMON: begin
					if (!(mo_q < MONTH_DEC && !dsum[DW-1])) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= req.opcode;
					m_q       <= req.month_in;
					d_q       <= req.day_in;
					delta_q   <= req.day_delta[DBW-1:0];
					yreg_q    <= YW'(req.year_in) - YW'(1);
					dreg_q    <= '0;
					res_y_q   <= req.year_in;
					res_m_q   <= req.month_in;
					res_d_q   <= req.day_in;
					res_ord_q <= '0;
					res_err_q <= !pre_ok;
				end
			end
			S_FWD: begin
				if (!ysum[YW]) begin
					yreg_q <= ysum[YW-1:0];
					dreg_q <= dsum;
				end else begin
					case (stage_q)
						STG_100: n100_q <= cnt_q[1:0];
						STG_4:   n4_q   <= cnt_q;
						STG_1: begin
							leap_q  <= leap_next;
							mo_q    <= 4'd1;
							ydays_q <= dreg_q;
							dreg_q  <= '0;
						end
						default: n100_q <= n100_q;
					endcase
				end
			end
			S_MON: begin
				if (mo_q < m_q) begin
					dreg_q <= dsum;
					mo_q   <= mo_q + 4'd1;
				end else if (d_q > len_m) begin
					res_err_q <= 1'b1;
				end else begin
					dreg_q <= dsum;
				end
			end
			S_DOY: begin
				if (op_q == OP_DOY) begin
					res_ord_q <= ord_ext[ORD_W-1:0];
				end else begin
					dreg_q <= dsum;
				end
			end
			S_EPOCH: begin
				if (op_q == OP_EPOCH) begin
					res_ord_q <= ord_ext[ORD_W-1:0];
				end else begin
					dreg_q <= dsum;
				end
			end
			S_CHK: begin
				yreg_q <= YW'(1);
				if ((is_sub_op && dreg_q[DW-1]) || (!is_sub_op && dreg_q > LAST_V)) begin
					res_err_q <= 1'b1;
				end
			end
			S_REV: begin
				if (!dsum[DW-1] && !rev_cap) begin
					yreg_q <= ysum[YW-1:0];
					dreg_q <= dsum;
				end else begin
					case (stage_q)
						STG_100: n100_q <= cnt_q[1:0];
						STG_4:   n4_q   <= cnt_q;
						STG_1: begin
							leap_q <= leap_next;
							mo_q   <= 4'd1;
						end
						default: n100_q <= n100_q;
					endcase
				end
			end
			S_RMON: begin
				if (mo_q < MONTH_DEC && !dsum[DW-1]) begin
					dreg_q <= dsum;
					mo_q   <= mo_q + 4'd1;
				end else begin
					res_y_q <= yreg_q[YEAR_W-1:0];
					res_m_q <= mo_q;
					res_d_q <= dreg_q[DAY_W-1:0] + 5'd1;
				end
			end
			default: begin
				dreg_q <= dreg_q;
			end
		endcase
	end

	// Output register: frees the core while a result waits on the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oy_q   <= res_y_q;
			om_q   <= res_m_q;
			od_q   <= res_d_q;
			oord_q <= res_ord_q;
			oerr_q <= res_err_q;
		end
	end

	assign rsp.valid     = ovld_q;
	assign rsp.year_out  = oy_q;
	assign rsp.month_out = om_q;
	assign rsp.day_out   = od_q;
	assign rsp.ordinal   = oord_q;
	assign rsp.error     = oerr_q;

	`CDA_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "request taken but core stayed idle")
	`CDA_ASSERT_NXT(a_load_shows_valid, load, rsp.valid, "result loaded but rsp.valid low")
	`CDA_ASSERT_IMP(a_rev_cap, state_q == S_REV && stage_q == STG_100, cnt_q <= 5'd3, "more than three century blocks in the walk back")
	`CDA_ASSERT_IMP(a_month_range, rsp.valid && !rsp.error, rsp.month_out != '0 && rsp.month_out <= MONTH_DEC && rsp.day_out != '0, "good result with month or day out of range")

endmodule
